/* sv/heap_sorter_assert.svh */
// Assertion macros for the heap sorter
`ifndef HEAP_SORTER_ASSERT_SVH
`define HEAP_SORTER_ASSERT_SVH

`ifndef SYNTH
// property must hold at every rising clock edge out of reset
`define HS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression must never be true out of reset
`define HS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define HS_ASSERT(lbl, clk, rstn, prop, msg)
`define HS_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* sv/hsort_pkg.sv */
package hsort_pkg;

  // default store depth
  localparam int DEPTH_DEF = 64;
  // width of the step counter
  localparam int UW = 5;

  // datapath commands, one per microcode step
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_NOP,
    OP_BUILD_INIT,
    OP_BUILD_NEXT,
    OP_SF_READ,
    OP_SF_LOAD,
    OP_SF_KIDS,
    OP_SF_CMP,
    OP_SF_END,
    OP_EX_INIT,
    OP_EX_READ,
    OP_EX_W0,
    OP_EX_W1,
    OP_EM_INIT,
    OP_EM_READ,
    OP_EM_OUT,
    OP_DONE
  } op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_FINAL,
    C_I_ZERO,
    C_I_LE1,
    C_NO_LEFT,
    C_SWAP,
    C_NOT_LAST,
    C_RET
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [UW-1:0]   target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic final_req;
    logic i_zero;
    logic i_le1;
    logic no_left;
    logic swap;
    logic not_last;
  } stat_t;

  // step addresses
  localparam logic [UW-1:0] ST_IDLE       = 5'd0;
  localparam logic [UW-1:0] ST_BUILD_INIT = 5'd1;
  localparam logic [UW-1:0] ST_BUILD_CHK  = 5'd2;
  localparam logic [UW-1:0] ST_BUILD_NEXT = 5'd3;
  localparam logic [UW-1:0] ST_SF_READ    = 5'd4;
  localparam logic [UW-1:0] ST_SF_LOAD    = 5'd5;
  localparam logic [UW-1:0] ST_SF_KIDS    = 5'd6;
  localparam logic [UW-1:0] ST_SF_CMP     = 5'd7;
  localparam logic [UW-1:0] ST_SF_END     = 5'd8;
  localparam logic [UW-1:0] ST_EX_INIT    = 5'd9;
  localparam logic [UW-1:0] ST_EX_CHK     = 5'd10;
  localparam logic [UW-1:0] ST_EX_READ    = 5'd11;
  localparam logic [UW-1:0] ST_EX_W0      = 5'd12;
  localparam logic [UW-1:0] ST_EX_W1      = 5'd13;
  localparam logic [UW-1:0] ST_EM_INIT    = 5'd14;
  localparam logic [UW-1:0] ST_EM_READ    = 5'd15;
  localparam logic [UW-1:0] ST_EM_OUT     = 5'd16;
  localparam logic [UW-1:0] ST_DONE       = 5'd17;

  // microcode store: taken jump to target or return step, else next step
  function automatic ctrl_t hsort_rom(input logic [UW-1:0] addr);
    ctrl_t w;
    unique case (addr)
      ST_IDLE:       w = '{OP_IDLE,       C_NOT_FINAL, ST_IDLE};
      ST_BUILD_INIT: w = '{OP_BUILD_INIT, C_NONE,      ST_IDLE};
      ST_BUILD_CHK:  w = '{OP_NOP,        C_I_ZERO,    ST_EX_INIT};
      ST_BUILD_NEXT: w = '{OP_BUILD_NEXT, C_NONE,      ST_IDLE};
      ST_SF_READ:    w = '{OP_SF_READ,    C_NONE,      ST_IDLE};
      ST_SF_LOAD:    w = '{OP_SF_LOAD,    C_NONE,      ST_IDLE};
      ST_SF_KIDS:    w = '{OP_SF_KIDS,    C_NO_LEFT,   ST_SF_END};
      ST_SF_CMP:     w = '{OP_SF_CMP,     C_SWAP,      ST_SF_KIDS};
      ST_SF_END:     w = '{OP_SF_END,     C_RET,       ST_IDLE};
      ST_EX_INIT:    w = '{OP_EX_INIT,    C_NONE,      ST_IDLE};
      ST_EX_CHK:     w = '{OP_NOP,        C_I_LE1,     ST_EM_INIT};
      ST_EX_READ:    w = '{OP_EX_READ,    C_NONE,      ST_IDLE};
      ST_EX_W0:      w = '{OP_EX_W0,      C_NONE,      ST_IDLE};
      ST_EX_W1:      w = '{OP_EX_W1,      C_ALWAYS,    ST_SF_READ};
      ST_EM_INIT:    w = '{OP_EM_INIT,    C_NONE,      ST_IDLE};
      ST_EM_READ:    w = '{OP_EM_READ,    C_NONE,      ST_IDLE};
      ST_EM_OUT:     w = '{OP_EM_OUT,     C_NOT_LAST,  ST_EM_READ};
      ST_DONE:       w = '{OP_DONE,       C_ALWAYS,    ST_IDLE};
      default:       w = '{OP_NOP,        C_ALWAYS,    ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/heap_sorter.sv */
// Heap sorter: collects a set of signed 32-bit values and returns them in
// ascending signed order.
// Input: a request is taken on a rising edge with start_i high and busy_o
// low; sample_value_i is stored and is_final_i marks the last value of the
// set. Collection accepts one value per cycle, back to back.
// The final request raises busy_o while a microcoded sequencer heapsorts the
// store: max-heap build from the last parent down, then root extraction.
// Each sift level reads both children, then compares and, on a swap, writes
// through the single store write port; once the store is sorted, each result
// is read from the store and sent out in ascending order.
// Output: each result is shown for one cycle with result_valid_o high;
// end_of_run_o marks the largest and last one, overflow_o is set on every
// result of a set that had values beyond DEPTH dropped. Results cannot be
// held off. busy_o falls the cycle after the last result.
// Reset empties the set and clears the drop flag; store contents are
// not cleared, only entries written in the current set are read.
`include "heap_sorter_assert.svh"

module heap_sorter #(
  parameter int DEPTH = hsort_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] sample_value_i,
  input  logic               is_final_i,
  output logic               result_valid_o,
  output logic signed [31:0] sorted_value_o,
  output logic               end_of_run_o,
  output logic               overflow_o
);
  import hsort_pkg::*;

  op_e   op;
  stat_t stat;

  // step counter and microcode store
  hsort_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op),
    .busy_o (busy_o)
  );

  // store, index registers and compare
  hsort_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .start_i        (start_i),
    .sample_value_i (sample_value_i),
    .is_final_i     (is_final_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .end_of_run_o   (end_of_run_o),
    .overflow_o     (overflow_o)
  );

  // results appear only while a sort is running
  `HS_ASSERT(a_res_in_busy, clk_i, rst_ni, result_valid_o |-> busy_o, "result outside sort")
  // the last result ends the run
  `HS_ASSERT(a_eor_ends, clk_i, rst_ni, (result_valid_o && end_of_run_o) |=> !busy_o, "run did not end")
  // a final request starts the sort
  `HS_ASSERT(a_final_starts, clk_i, rst_ni, (start_i && !busy_o && is_final_i) |=> busy_o, "sort not started")
  // no two results in consecutive cycles
  `HS_ASSERT_NEVER(a_res_spacing, clk_i, rst_ni, result_valid_o && $past(result_valid_o), "results too close")

endmodule

/* sv/hsort_seq.sv */
module hsort_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hsort_pkg::stat_t stat_i,
  output hsort_pkg::op_e  op_o,
  output logic            busy_o
);
  import hsort_pkg::*;

  logic [UW-1:0] upc_q, upc_d;
  logic          ret_q, ret_d;
  ctrl_t         ctrl;
  logic          take;

  // fetch the control word of the current step
  assign ctrl   = hsort_rom(upc_q);
  assign op_o   = ctrl.op;
  assign busy_o = (upc_q != ST_IDLE);

  // jump condition select
  always_comb begin
    unique case (ctrl.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_FINAL: take = !stat_i.final_req;
      C_I_ZERO:    take = stat_i.i_zero;
      C_I_LE1:     take = stat_i.i_le1;
      C_NO_LEFT:   take = stat_i.no_left;
      C_SWAP:      take = stat_i.swap;
      C_NOT_LAST:  take = stat_i.not_last;
      C_RET:       take = 1'b1;
      default:     take = 1'b0;
    endcase
  end

  // next step; the sift routine returns to build or extraction loop
  always_comb begin
    ret_d = ret_q;
    if (ctrl.op == OP_BUILD_INIT) begin
      ret_d = 1'b0;
    end else if (ctrl.op == OP_EX_INIT) begin
      ret_d = 1'b1;
    end
    if (!take) begin
      upc_d = upc_q + UW'(1);
    end else if (ctrl.cond == C_RET) begin
      upc_d = ret_q ? ST_EX_CHK : ST_BUILD_CHK;
    end else begin
      upc_d = ctrl.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_IDLE;
      ret_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      ret_q <= ret_d;
    end
  end

endmodule

/* sv/hsort_dp.sv */
module hsort_dp #(
  parameter int DEPTH = hsort_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsort_pkg::op_e     op_i,
  input  logic               start_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               is_final_i,
  output hsort_pkg::stat_t   stat_o,
  output logic               result_valid_o,
  output logic signed [31:0] sorted_value_o,
  output logic               end_of_run_o,
  output logic               overflow_o
);
  import hsort_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd0_q, rd1_q, v_q, t_q;
  logic signed [31:0] res_q;
  logic [AW-1:0]      nd_q, ra0, ra1, wa, cidx;
  logic [CW-1:0]      lv_q, i_q, cnt_q, i_dec, i_inc;
  logic               drop_q, valid_q, eor_q, ovf_q;
  logic [XW-1:0]      left_x, right_x, lv_x;
  logic               has_left, has_right, rsel, swap, full, we;
  logic signed [31:0] cval, wd;

  // child indices and the larger-child compare
  assign left_x    = XW'({nd_q, 1'b1});
  assign right_x   = left_x + XW'(1);
  assign lv_x      = XW'(lv_q);
  assign has_left  = left_x < lv_x;
  assign has_right = right_x < lv_x;
  assign rsel      = has_right && (rd1_q > rd0_q);
  assign cval      = rsel ? rd1_q : rd0_q;
  assign cidx      = rsel ? right_x[AW-1:0] : left_x[AW-1:0];
  assign swap      = cval > v_q;
  assign i_dec     = i_q - CW'(1);
  assign i_inc     = i_q + CW'(1);
  assign full      = (cnt_q == CW'(DEPTH));

  // status to the sequencer
  assign stat_o.final_req = start_i && is_final_i;
  assign stat_o.i_zero    = (i_q == '0);
  assign stat_o.i_le1     = (i_q <= CW'(1));
  assign stat_o.no_left   = !has_left;
  assign stat_o.swap      = swap;
  assign stat_o.not_last  = (i_inc != cnt_q);

  // read addresses
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    unique case (op_i)
      OP_SF_READ: ra0 = nd_q;
      OP_SF_KIDS: begin
        ra0 = left_x[AW-1:0];
        ra1 = right_x[AW-1:0];
      end
      OP_EX_READ: ra1 = i_dec[AW-1:0];
      OP_EM_READ: ra0 = i_q[AW-1:0];
      default: ;
    endcase
  end

  // single write port
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = sample_value_i;
    unique case (op_i)
      OP_IDLE: begin
        we = start_i && !full;
        wa = cnt_q[AW-1:0];
      end
      OP_SF_CMP: begin
        we = swap;
        wa = nd_q;
        wd = cval;
      end
      OP_SF_END: begin
        we = 1'b1;
        wa = nd_q;
        wd = v_q;
      end
      OP_EX_W0: begin
        we = 1'b1;
        wd = rd1_q;
      end
      OP_EX_W1: begin
        we = 1'b1;
        wa = i_dec[AW-1:0];
        wd = t_q;
      end
      default: ;
    endcase
  end

  // store with registered read data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  // control state: fill count, drop flag, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (op_i == OP_EM_OUT);
      if (op_i == OP_IDLE && start_i) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end else if (op_i == OP_DONE) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end
    end
  end

  // working registers of the sort
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_BUILD_INIT: begin
        i_q  <= cnt_q >> 1;
        lv_q <= cnt_q;
      end
      OP_BUILD_NEXT: begin
        i_q  <= i_dec;
        nd_q <= i_dec[AW-1:0];
      end
      OP_SF_LOAD: v_q <= rd0_q;
      OP_SF_CMP: begin
        if (swap) begin
          nd_q <= cidx;
        end
      end
      OP_EX_INIT: i_q <= cnt_q;
      OP_EX_W0:   t_q <= rd0_q;
      OP_EX_W1: begin
        i_q  <= i_dec;
        lv_q <= i_dec;
        nd_q <= '0;
      end
      OP_EM_INIT: i_q <= '0;
      OP_EM_OUT: begin
        i_q   <= i_inc;
        res_q <= rd0_q;
        eor_q <= (i_inc == cnt_q);
        ovf_q <= drop_q;
      end
      default: ;
    endcase
  end

  assign result_valid_o = valid_q;
  assign sorted_value_o = res_q;
  assign end_of_run_o   = eor_q;
  assign overflow_o     = ovf_q;

endmodule

/* tb/heap_sorter_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the heap sorter, predicts the sorted run of each
// set and compares every result against it.
module heap_sorter_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               is_final_i,
  input  logic               result_valid_i,
  input  logic signed [31:0] sorted_value_i,
  input  logic               end_of_run_i,
  input  logic               overflow_i,
  output int                 mismatches_o,
  output int                 outstanding_o,
  output int                 checked_o
);

  localparam int DEPTH = hsort_pkg::DEPTH_DEF;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               dropped;
  } sorted_item_t;

  // model of the set being collected
  logic signed [31:0] set_vals [DEPTH];
  int                 set_fill;
  logic               set_dropped;

  sorted_item_t       run_q [$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    checked_o     = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [31:0] ordered [DEPTH];
    logic signed [31:0] key;
    sorted_item_t       exp_item;
    int                 j;
    if (!rst_ni) begin
      set_fill    = 0;
      set_dropped = 1'b0;
    end else begin
      // compare a result with the oldest prediction
      if (result_valid_i) begin
        checked_o++;
        if (run_q.size() == 0) begin
          $error("unexpected result: sorted_value %0d end_of_run %0b overflow %0b",
                 sorted_value_i, end_of_run_i, overflow_i);
          mismatches_o++;
        end else begin
          exp_item = run_q.pop_front();
          if (sorted_value_i !== exp_item.value) begin
            $error("sorted_value: expected %0d, got %0d", exp_item.value, sorted_value_i);
            mismatches_o++;
          end
          if (end_of_run_i !== exp_item.last) begin
            $error("end_of_run: expected %0b, got %0b", exp_item.last, end_of_run_i);
            mismatches_o++;
          end
          if (overflow_i !== exp_item.dropped) begin
            $error("overflow: expected %0b, got %0b", exp_item.dropped, overflow_i);
            mismatches_o++;
          end
        end
      end

      // accepted request: store, or drop once the store is full
      if (start_i && !busy_i) begin
        if (set_fill < DEPTH) begin
          set_vals[set_fill] = sample_value_i;
          set_fill++;
        end else begin
          set_dropped = 1'b1;
        end

        // final request: predict the whole ascending run
        if (is_final_i) begin
          for (int i = 0; i < set_fill; i++) begin
            key = set_vals[i];
            j   = i - 1;
            while (j >= 0 && ordered[j] > key) begin
              ordered[j + 1] = ordered[j];
              j--;
            end
            ordered[j + 1] = key;
          end
          for (int k = 0; k < set_fill; k++) begin
            exp_item.value   = ordered[k];
            exp_item.last    = (k == set_fill - 1);
            exp_item.dropped = set_dropped;
            run_q.push_back(exp_item);
          end
          set_fill    = 0;
          set_dropped = 1'b0;
        end
      end
    end
    outstanding_o = run_q.size();
  end

endmodule

/* tb/tb_heap_sorter.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the heap sorter; checking sits in the checker.
module tb_heap_sorter;

  localparam int DEPTH       = hsort_pkg::DEPTH_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 145;

  localparam logic signed [31:0] S_MIN = 32'h8000_0000;
  localparam logic signed [31:0] S_MAX = 32'h7FFF_FFFF;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [31:0] sample_value_i;
  logic               is_final_i;
  logic               result_valid_o;
  logic signed [31:0] sorted_value_o;
  logic               end_of_run_o;
  logic               overflow_o;

  int mismatches;
  int outstanding;
  int checked;

  // run statistics
  int items_sent;
  int sets_sent;
  int biggest_set;
  int lossy_sets;
  int idle_cycles;

  logic signed [31:0] set_buf [$];

  heap_sorter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_value_i (sample_value_i),
    .is_final_i     (is_final_i),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .end_of_run_o   (end_of_run_o),
    .overflow_o     (overflow_o)
  );

  heap_sorter_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .sample_value_i (sample_value_i),
    .is_final_i     (is_final_i),
    .result_valid_i (result_valid_o),
    .sorted_value_i (sorted_value_o),
    .end_of_run_i   (end_of_run_o),
    .overflow_i     (overflow_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one request; the sender pauses now and then, except in a steady stretch
  task automatic send_request(input logic signed [31:0] value, input logic fin);
    int gap;
    @(negedge clk_i);
    if (!(items_sent >= 60 && items_sent < 130) && $urandom_range(0, 99) < 4) begin
      gap = $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i        <= 1'b1;
    sample_value_i <= value;
    is_final_i     <= fin;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  // send the buffered set, final mark on its last value
  task automatic send_set();
    for (int i = 0; i < set_buf.size(); i++)
      send_request(set_buf[i], i == set_buf.size() - 1);
    sets_sent++;
    if (set_buf.size() > biggest_set) biggest_set = set_buf.size();
    if (set_buf.size() > DEPTH) lossy_sets++;
    set_buf.delete();
  endtask

  // stall watchdog: no request and no result for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int set_len;
    int rand_sent;
    int set_no;
    start_i        = 1'b0;
    sample_value_i = '0;
    is_final_i     = 1'b0;
    items_sent     = 0;
    sets_sent      = 0;
    biggest_set    = 0;
    lossy_sets     = 0;
    idle_cycles    = 0;
    rand_sent      = 0;
    set_no         = 0;
    rst_ni         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: single-value sets at both extremes
    set_buf = '{S_MIN};
    send_set();
    set_buf = '{S_MAX};
    send_set();
    // extremes, sign boundary, alternating bit patterns and duplicates
    set_buf = '{S_MAX, S_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sh5555_5555,
                32'shAAAA_AAAA, 32'sd7, 32'sd7, -32'sd7, 32'sd0};
    send_set();
    set_buf = '{32'sd3, -32'sd3};
    send_set();
    // all equal, then strictly descending
    set_buf = '{32'sd5, 32'sd5, 32'sd5, 32'sd5};
    send_set();
    set_buf = '{32'sd100, 32'sd50, -32'sd50, -32'sd100};
    send_set();

    // random sets: mostly short, one exactly full, one that overflows
    while (rand_sent < RAND_ITEMS) begin
      if (set_no == 2)
        set_len = DEPTH;
      else if (set_no == 5)
        set_len = DEPTH + $urandom_range(1, 6);
      else if ($urandom_range(0, 11) == 0)
        set_len = $urandom_range(11, 24);
      else
        set_len = $urandom_range(1, 10);
      for (int i = 0; i < set_len; i++) begin
        case ($urandom_range(0, 9))
          5, 6:    set_buf.push_back($signed($urandom_range(0, 8)) - 4);
          7:       set_buf.push_back(S_MIN);
          8:       set_buf.push_back(S_MAX);
          9:       set_buf.push_back(-32'sd1);
          default: set_buf.push_back($urandom);
        endcase
      end
      send_set();
      rand_sent += set_len;
      set_no++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;

    // drain, then allow time for stray results
    while (outstanding != 0) @(posedge clk_i);
    repeat (16) @(negedge clk_i);

    $display("Covered %0d values in %0d sets, largest %0d, %0d with dropped values.",
             items_sent, sets_sent, biggest_set, lossy_sets);
    $display("%0d sorted results compared, %0d mismatches.", checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
